// ===== hw/rtl/ihdi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the image header dimension inspect unit.
// No dependencies.
package ihdi_pkg;

   localparam int HDR_USED = 30;            // header bytes the decoders look at
   localparam logic [5:0] POS_MAX = 6'd63;  // byte count saturates here

   localparam logic [2:0] FMT_NONE = 3'd0;
   localparam logic [2:0] FMT_JPEG = 3'd1;
   localparam logic [2:0] FMT_PNG  = 3'd2;
   localparam logic [2:0] FMT_GIF  = 3'd3;
   localparam logic [2:0] FMT_WEBP = 3'd4;
   localparam logic [2:0] FMT_BMP  = 3'd5;

   localparam logic [1:0] VERDICT_INVALID   = 2'd0;
   localparam logic [1:0] VERDICT_UNSAFE    = 2'd1;
   localparam logic [1:0] VERDICT_COMPLIANT = 2'd2;
   localparam logic [1:0] VERDICT_NORMALIZE = 2'd3;

   localparam logic [1:0] CSR_PIXEL_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_SIDE_SUM_LIMIT = 2'd1;
   localparam logic [1:0] CSR_ASPECT_LIMIT   = 2'd2;

   typedef enum logic [1:0] {
      JPEG_PENDING,
      JPEG_FOUND,
      JPEG_FAILED
   } jpeg_outcome_type;

   typedef struct packed {
      jpeg_outcome_type outcome;
      logic [15:0]      width;
      logic [15:0]      height;
   } jpeg_result_type;

   typedef struct packed {
      logic [2:0]  fmt;
      logic [31:0] width;
      logic [31:0] height;
   } dim_type;

endpackage

// ===== hw/rtl/ihdi_jpeg_walker.sv =====
`timescale 1ns / 1ps
// JPEG marker-segment walker: one byte per beat, gives its post-beat state.
// Depends on ihdi_pkg.
module ihdi_jpeg_walker
   import ihdi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            beat,
   input  logic            beat_last,
   input  logic [7:0]      beat_byte,
   input  logic            past_magic,   // byte count >= 2
   output jpeg_result_type result_next
);

   typedef enum logic [2:0] {
      PH_SEEK,
      PH_FILL,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [15:0]      countdown_ff, countdown_in;
   logic [7:0]       lhb_ff, lhb_in;
   logic             frame_ff, frame_in;
   logic [15:0]      hgt_ff, hgt_in;
   logic [15:0]      wid_ff, wid_in;
   jpeg_outcome_type outcome_ff, outcome_in;
   logic [15:0]      seg_len;
   logic             walk_en;

   assign walk_en = beat && past_magic && (outcome_ff == JPEG_PENDING);
   assign seg_len = {lhb_ff, beat_byte};

   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      lhb_in       = lhb_ff;
      frame_in     = frame_ff;
      hgt_in       = hgt_ff;
      wid_in       = wid_ff;
      outcome_in   = outcome_ff;
      if (walk_en) begin
         case (phase_ff)
            PH_SEEK: begin
               if (beat_byte == 8'hff) phase_in = PH_FILL;
            end
            PH_FILL: begin
               if (beat_byte == 8'hff) begin
                  phase_in = PH_FILL;  // fill byte
               end else if (beat_byte inside {8'h00, 8'h01, 8'hd8, [8'hd0:8'hd7]}) begin
                  phase_in = PH_SEEK;
               end else if (beat_byte inside {8'hd9, 8'hda}) begin
                  outcome_in = JPEG_FAILED;
               end else begin
                  frame_in = (beat_byte[7:4] == 4'hc) &&
                             !(beat_byte inside {8'hc4, 8'hc8, 8'hcc});
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               lhb_in   = beat_byte;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (seg_len < 16'd2 || (frame_ff && seg_len < 16'd7)) begin
                  outcome_in = JPEG_FAILED;
               end else begin
                  countdown_in = seg_len - 16'd2;
                  lhb_in       = 8'd0;
                  phase_in     = (seg_len == 16'd2) ? PH_SEEK : PH_BODY;
               end
            end
            PH_BODY: begin
               // lhb counts the first body bytes of a frame segment
               if (frame_ff && lhb_ff < 8'd5) begin
                  if (lhb_ff == 8'd1 || lhb_ff == 8'd2) hgt_in = {hgt_ff[7:0], beat_byte};
                  if (lhb_ff == 8'd3 || lhb_ff == 8'd4) wid_in = {wid_ff[7:0], beat_byte};
                  lhb_in = lhb_ff + 8'd1;
               end
               countdown_in = countdown_ff - 16'd1;
               if (countdown_ff == 16'd1) begin
                  if (frame_ff) outcome_in = JPEG_FOUND;
                  else phase_in = PH_SEEK;
               end
            end
            default: begin
               phase_in = PH_SEEK;
            end
         endcase
      end
   end

   assign result_next = '{outcome: outcome_in, width: wid_in, height: hgt_in};

   always_ff @(posedge clock) begin
      if (reset || (beat && beat_last)) begin
         phase_ff     <= PH_SEEK;
         countdown_ff <= 16'd0;
         lhb_ff       <= 8'd0;
         frame_ff     <= 1'b0;
         hgt_ff       <= 16'd0;
         wid_ff       <= 16'd0;
         outcome_ff   <= JPEG_PENDING;
      end else if (beat) begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         lhb_ff       <= lhb_in;
         frame_ff     <= frame_in;
         hgt_ff       <= hgt_in;
         wid_ff       <= wid_in;
         outcome_ff   <= outcome_in;
      end
   end

endmodule

// ===== hw/rtl/ihdi_format_decode.sv =====
`timescale 1ns / 1ps
// Header byte store, byte counter and fixed-offset format decoders.
// Registers format and dimensions each advance, valid for the last beat. Depends on ihdi_pkg.
module ihdi_format_decode
   import ihdi_pkg::*;
#(
   parameter int HEADER_DEPTH = 30
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            beat,
   input  logic            beat_last,
   input  logic [7:0]      beat_byte,
   input  jpeg_result_type jpeg_next,
   output logic            past_magic,
   output logic            dec_valid,
   output dim_type         dec_dim
);

   localparam int IDX_W = $clog2(HEADER_DEPTH);

   logic [7:0]  store_ff [HEADER_DEPTH];
   logic [5:0]  pos_ff;
   logic [7:0]  v [HDR_USED];
   logic [6:0]  n;
   logic        dec_valid_ff;
   dim_type     dec_ff, dec_in;

   assign past_magic = (pos_ff >= 6'd2);
   assign n = {1'b0, pos_ff} + 7'd1;

   // current beat merged over the store
   always_comb begin
      for (int i = 0; i < HDR_USED; i++) begin
         v[i] = (pos_ff == 6'(i)) ? beat_byte : store_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (beat && ({1'b0, pos_ff} < 7'(HEADER_DEPTH))) begin
         store_ff[pos_ff[IDX_W-1:0]] <= beat_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (beat && beat_last)) begin
         pos_ff <= 6'd0;
      end else if (beat && pos_ff != POS_MAX) begin
         pos_ff <= pos_ff + 6'd1;
      end
   end

   always_comb begin
      logic [31:0] cs;
      logic [31:0] dib;
      logic [31:0] rw;
      logic [31:0] rh;
      logic [31:0] tw;
      logic [31:0] th;
      logic        riff;
      cs   = {v[19], v[18], v[17], v[16]};
      dib  = {v[17], v[16], v[15], v[14]};
      rw   = {v[21], v[20], v[19], v[18]};
      rh   = {v[25], v[24], v[23], v[22]};
      riff = n >= 7'd20 && v[0] == 8'h52 && v[1] == 8'h49 && v[2] == 8'h46 &&
             v[3] == 8'h46 && v[8] == 8'h57 && v[9] == 8'h45 && v[10] == 8'h42 &&
             v[11] == 8'h50 && v[12] == 8'h56 && v[13] == 8'h50 && v[14] == 8'h38;
      dec_in = '{fmt: FMT_NONE, width: 32'd0, height: 32'd0};
      tw = 32'd0;
      th = 32'd0;
      if (n >= 7'd4 && v[0] == 8'hff && v[1] == 8'hd8 && jpeg_next.outcome == JPEG_FOUND &&
          jpeg_next.width != 16'd0 && jpeg_next.height != 16'd0) begin
         dec_in = '{fmt: FMT_JPEG, width: {16'd0, jpeg_next.width},
                    height: {16'd0, jpeg_next.height}};
      end else if (n >= 7'd24 && {v[8], v[9], v[10], v[11]} == 32'd13 && v[0] == 8'h89 &&
                   v[1] == 8'h50 && v[2] == 8'h4e && v[3] == 8'h47 && v[4] == 8'h0d &&
                   v[5] == 8'h0a && v[6] == 8'h1a && v[7] == 8'h0a && v[12] == 8'h49 &&
                   v[13] == 8'h48 && v[14] == 8'h44 && v[15] == 8'h52 &&
                   {v[16], v[17], v[18], v[19]} != 32'd0 &&
                   {v[20], v[21], v[22], v[23]} != 32'd0) begin
         dec_in = '{fmt: FMT_PNG, width: {v[16], v[17], v[18], v[19]},
                    height: {v[20], v[21], v[22], v[23]}};
      end else if (n >= 7'd10 && v[0] == 8'h47 && v[1] == 8'h49 && v[2] == 8'h46 &&
                   v[3] == 8'h38 && (v[4] == 8'h37 || v[4] == 8'h39) && v[5] == 8'h61 &&
                   {v[7], v[6]} != 16'd0 && {v[9], v[8]} != 16'd0) begin
         dec_in = '{fmt: FMT_GIF, width: {16'd0, v[7], v[6]}, height: {16'd0, v[9], v[8]}};
      end else if (riff && v[15] == 8'h58 && cs >= 32'd10 && n >= 7'd30) begin
         // VP8X: 24-bit sizes minus one
         tw = {8'd0, v[26], v[25], v[24]} + 32'd1;
         th = {8'd0, v[29], v[28], v[27]} + 32'd1;
         dec_in = '{fmt: FMT_WEBP, width: tw, height: th};
      end else if (riff && v[15] == 8'h20 && cs >= 32'd10 && n >= 7'd30 &&
                   v[23] == 8'h9d && v[24] == 8'h01 && v[25] == 8'h2a &&
                   {v[27][5:0], v[26]} != 14'd0 && {v[29][5:0], v[28]} != 14'd0) begin
         dec_in = '{fmt: FMT_WEBP, width: {18'd0, v[27][5:0], v[26]},
                    height: {18'd0, v[29][5:0], v[28]}};
      end else if (riff && v[15] == 8'h4c && cs >= 32'd5 && n >= 7'd25 &&
                   v[20] == 8'h2f) begin
         tw = {18'd0, v[22][5:0], v[21]} + 32'd1;
         th = {18'd0, v[24][3:0], v[23], v[22][7:6]} + 32'd1;
         dec_in = '{fmt: FMT_WEBP, width: tw, height: th};
      end else if (n >= 7'd26 && v[0] == 8'h42 && v[1] == 8'h4d) begin
         if (dib == 32'd12) begin
            if ({v[19], v[18]} != 16'd0 && {v[21], v[20]} != 16'd0) begin
               dec_in = '{fmt: FMT_BMP, width: {16'd0, v[19], v[18]},
                          height: {16'd0, v[21], v[20]}};
            end
         end else if (dib >= 32'd40) begin
            if (rw != 32'd0 && !rw[31] && rh != 32'd0 && rh != 32'h8000_0000) begin
               th = rh[31] ? (~rh + 32'd1) : rh;
               dec_in = '{fmt: FMT_BMP, width: rw, height: th};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (advance) begin
         dec_valid_ff <= beat && beat_last;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) dec_ff <= dec_in;
   end

   assign dec_valid = dec_valid_ff;
   assign dec_dim   = dec_ff;

endmodule

// ===== hw/rtl/ihdi_verdict.sv =====
`timescale 1ns / 1ps
// Verdict stages: products and sums registered, then limit compares into
// the result register. Depends on ihdi_pkg.
module ihdi_verdict
   import ihdi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        dec_valid,
   input  dim_type     dec_dim,
   input  logic [39:0] pixel_limit,
   input  logic [17:0] side_sum_limit,
   input  logic [7:0]  aspect_limit,
   output logic        rsp_valid,
   output logic [1:0]  rsp_verdict,
   output dim_type     rsp_dim
);

   logic        mv_ff;
   dim_type     mdim_ff;
   logic [63:0] area_ff;
   logic [39:0] ar_ff;
   logic [32:0] sum_ff;
   logic [31:0] big_ff;
   logic [31:0] big, shorter;
   logic        out_valid_ff;
   logic [1:0]  verdict_ff, verdict_in;
   dim_type     out_dim_ff;

   assign big     = (dec_dim.width > dec_dim.height) ? dec_dim.width : dec_dim.height;
   assign shorter = (dec_dim.width > dec_dim.height) ? dec_dim.height : dec_dim.width;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (advance) begin
         mv_ff <= dec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mdim_ff <= dec_dim;
         area_ff <= 64'(dec_dim.width) * 64'(dec_dim.height);
         ar_ff   <= 40'(aspect_limit) * 40'(shorter);
         sum_ff  <= {1'b0, dec_dim.width} + {1'b0, dec_dim.height};
         big_ff  <= big;
      end
   end

   always_comb begin
      if (mdim_ff.fmt == FMT_NONE) begin
         verdict_in = VERDICT_INVALID;
      end else if (area_ff[63:40] != 24'd0 || area_ff[39:0] > pixel_limit) begin
         verdict_in = VERDICT_UNSAFE;
      end else if (sum_ff <= 33'(side_sum_limit) && 40'(big_ff) <= ar_ff) begin
         verdict_in = VERDICT_COMPLIANT;
      end else begin
         verdict_in = VERDICT_NORMALIZE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_ff <= verdict_in;
         out_dim_ff <= mdim_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_dim     = out_dim_ff;

endmodule

// ===== hw/rtl/image_header_dimension_inspect_unit.sv =====
`timescale 1ns / 1ps
// Image header dimension inspector: takes one byte per beat and, for the beat
// with tlast, returns one verdict with format and size; rsp_tvalid follows the
// accepted beat through in_valid_ff, dec_valid_ff, mv_ff and out_valid_ff. A byte is
// accepted every cycle while the pipeline (input register, walker/decode,
// multiply, compare/result) runs; it stalls only while a result waits on rsp_tready.
// Depends on ihdi_pkg, ihdi_jpeg_walker, ihdi_format_decode, ihdi_verdict.
module image_header_dimension_inspect_unit
   import ihdi_pkg::*;
#(
   parameter int HEADER_DEPTH = 30
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [1:0] verdict, [4:2] image_format,
                                    // [36:5] pixel_width, [68:37] pixel_height
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_wdata
);

   logic            advance;
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            beat;
   logic            past_magic;
   jpeg_result_type jpeg_next;
   logic            dec_valid;
   dim_type         dec_dim;
   logic [39:0]     pixel_limit_ff;
   logic [17:0]     side_sum_limit_ff;
   logic [7:0]      aspect_limit_ff;
   logic            out_valid;
   logic [1:0]      out_verdict;
   dim_type         out_dim;

   assign advance    = !out_valid || rsp_tready;
   assign req_tready = advance;
   assign beat       = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_limit_ff    <= 40'd100000000;
         side_sum_limit_ff <= 18'd10000;
         aspect_limit_ff   <= 8'd20;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_LIMIT:    pixel_limit_ff    <= csr_wdata;
            CSR_SIDE_SUM_LIMIT: side_sum_limit_ff <= csr_wdata[17:0];
            CSR_ASPECT_LIMIT:   aspect_limit_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   ihdi_jpeg_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .beat_last   (in_last_ff),
      .beat_byte   (in_byte_ff),
      .past_magic  (past_magic),
      .result_next (jpeg_next)
   );

   ihdi_format_decode #(
      .HEADER_DEPTH (HEADER_DEPTH)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .beat       (beat),
      .beat_last  (in_last_ff),
      .beat_byte  (in_byte_ff),
      .jpeg_next  (jpeg_next),
      .past_magic (past_magic),
      .dec_valid  (dec_valid),
      .dec_dim    (dec_dim)
   );

   ihdi_verdict u_verdict (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .dec_valid      (dec_valid),
      .dec_dim        (dec_dim),
      .pixel_limit    (pixel_limit_ff),
      .side_sum_limit (side_sum_limit_ff),
      .aspect_limit   (aspect_limit_ff),
      .rsp_valid      (out_valid),
      .rsp_verdict    (out_verdict),
      .rsp_dim        (out_dim)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {3'd0, out_dim.height, out_dim.width, out_dim.fmt, out_verdict};

endmodule
